// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: condition must never hold");

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/euc_pkg.sv
package euc_pkg;

  // sizing defaults
  localparam int HOST_SIZE_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RES_DEPTH       = 2;

  // port limits
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd4222;
  localparam logic [19:0] PORT_MAX         = 20'd65535;

  // scheme prefix
  localparam int PREFIX_LEN = 7;

  // character codes
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // classified byte as passed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       forbidden;
    logic       colon;
    logic       digit;
    logic [3:0] dval;
  } cls_t;

  // verdict for one string
  typedef struct packed {
    logic        accepted;
    logic        prefix_skipped;
    logic [5:0]  host_len;
    logic [15:0] port_number;
  } res_t;

  // "nats://" by position
  function automatic logic [7:0] scheme_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h6E;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h73;
      3'd4:    c = CH_COLON;
      3'd5:    c = CH_SLASH;
      3'd6:    c = CH_SLASH;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/euc_fifo.sv
module euc_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/euc_front.sv
module euc_front (
  input  logic          push,
  input  logic [7:0]    in_char_byte,
  input  logic          in_last_byte,
  input  logic          q_full,
  output logic          q_wr,
  output euc_pkg::cls_t q_item
);

  import euc_pkg::*;

  assign q_wr = push && !q_full;

  // byte classification
  always_comb begin
    q_item.ch        = in_char_byte;
    q_item.last      = in_last_byte;
    q_item.forbidden = in_char_byte inside {CH_AT, CH_SLASH, CH_QUEST, CH_SPACE,
                                            CH_TAB, CH_LBRACK, CH_RBRACK};
    q_item.colon     = (in_char_byte == CH_COLON);
    q_item.digit     = in_char_byte inside {[CH_ZERO:CH_NINE]};
    q_item.dval      = 4'(in_char_byte - CH_ZERO);
  end

endmodule

// File: hw/rtl/euc_back.sv
module euc_back #(
  parameter int HOST_SIZE = euc_pkg::HOST_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   default_port,
  input  logic          q_empty,
  input  euc_pkg::cls_t q_item,
  output logic          q_rd,
  input  logic          res_full,
  output logic          res_push,
  output euc_pkg::res_t res_item
);

  import euc_pkg::*;

  localparam int HCW = $clog2(HOST_SIZE + 1);

  logic [2:0]     pos_r, pos_nxt;
  logic           alive_r, alive_nxt;
  logic           colon_r, colon_nxt;
  logic [HCW-1:0] hc_r, hc_nxt;
  logic [15:0]    acc_r, acc_nxt;
  logic           hasd_r, hasd_nxt;
  logic           rej_r, rej_nxt;
  logic           handled;
  logic [19:0]    prod;
  logic           ok;

  assign q_rd     = !q_empty && !res_full;
  assign res_push = q_rd && q_item.last;

  // per-byte state update
  always_comb begin
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    colon_nxt = colon_r;
    hc_nxt    = hc_r;
    acc_nxt   = acc_r;
    hasd_nxt  = hasd_r;
    rej_nxt   = rej_r;
    handled   = 1'b0;
    prod      = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 20'(q_item.dval);

    // scheme prefix match
    if (alive_r && (pos_r < 3'(PREFIX_LEN))) begin
      if (q_item.ch == scheme_char(pos_r)) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == 3'(PREFIX_LEN - 1)) begin
          colon_nxt = 1'b0;
          hc_nxt    = '0;
          acc_nxt   = '0;
          hasd_nxt  = 1'b0;
          rej_nxt   = 1'b0;
          handled   = 1'b1;
        end
      end else begin
        alive_nxt = 1'b0;
      end
    end

    // host / port parse
    if (!handled) begin
      if (q_item.forbidden) begin
        rej_nxt = 1'b1;
      end else if (!colon_r) begin
        if (q_item.colon) begin
          colon_nxt = 1'b1;
        end else if (hc_r < HCW'(HOST_SIZE)) begin
          hc_nxt = hc_r + 1'b1;
        end
      end else if (!q_item.digit) begin
        rej_nxt = 1'b1;
      end else begin
        if (!rej_r) begin
          if (prod > PORT_MAX) begin
            rej_nxt = 1'b1;
            acc_nxt = '0;
          end else begin
            acc_nxt = prod[15:0];
          end
        end
        hasd_nxt = 1'b1;
      end
    end

    // verdict on the final byte
    ok = !rej_nxt && (hc_nxt != '0) && (hc_nxt < HCW'(HOST_SIZE));
    if (colon_nxt && (!hasd_nxt || (acc_nxt == '0))) begin
      ok = 1'b0;
    end
    res_item.accepted       = ok;
    res_item.prefix_skipped = ok && alive_nxt && (pos_nxt == 3'(PREFIX_LEN));
    res_item.host_len       = ok ? 6'(hc_nxt) : 6'd0;
    res_item.port_number    = !ok ? 16'd0 : (colon_nxt ? acc_nxt : default_port);
  end

  // parse state; cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (q_rd && q_item.last)) begin
      pos_r   <= '0;
      alive_r <= 1'b1;
      colon_r <= 1'b0;
      hc_r    <= '0;
      acc_r   <= '0;
      hasd_r  <= 1'b0;
      rej_r   <= 1'b0;
    end else if (q_rd) begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      colon_r <= colon_nxt;
      hc_r    <= hc_nxt;
      acc_r   <= acc_nxt;
      hasd_r  <= hasd_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

// File: hw/rtl/endpoint_url_checker_top.sv
// A verdict enters the verdict queue as its last byte is taken and shows on the out_ ports at its head.
// Throughput: one byte per cycle; the back end consumes a queued byte each cycle
// the result queue has room, so a stalled consumer backs up into full.
// Reset: synchronous active-low rst_n empties both queues, clears parse state and
// loads default_port with 4222.
`include "assert_macros.svh"

module endpoint_url_checker_top #(
  parameter int HOST_SIZE   = euc_pkg::HOST_SIZE_DEF,
  parameter int QUEUE_DEPTH = euc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte requests
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_byte,
  input  logic        in_last_byte,
  // verdict requests
  output logic        empty,
  input  logic        pop,
  output logic        out_accepted,
  output logic        out_prefix_skipped,
  output logic [5:0]  out_host_len,
  output logic [15:0] out_port_number,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import euc_pkg::*;

  logic        cls_wr, cls_rd, cls_empty;
  cls_t        cls_wr_item, cls_rd_item;
  logic        res_push, res_full;
  res_t        res_wr_item, res_rd_item;
  logic [15:0] default_port_r;

  // default port register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r <= DEFAULT_PORT_RST;
    end else if (cfg_wr_en) begin
      default_port_r <= cfg_wr_data;
    end
  end

  euc_front u_front (
    .push         (push),
    .in_char_byte (in_char_byte),
    .in_last_byte (in_last_byte),
    .q_full       (full),
    .q_wr         (cls_wr),
    .q_item       (cls_wr_item)
  );

  // front-to-back byte queue
  euc_fifo #(.item_t(cls_t), .DEPTH(QUEUE_DEPTH)) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cls_wr),
    .wr_data (cls_wr_item),
    .full    (full),
    .rd_en   (cls_rd),
    .rd_data (cls_rd_item),
    .empty   (cls_empty)
  );

  euc_back #(.HOST_SIZE(HOST_SIZE)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .default_port (default_port_r),
    .q_empty      (cls_empty),
    .q_item       (cls_rd_item),
    .q_rd         (cls_rd),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_item     (res_wr_item)
  );

  // verdict queue
  euc_fifo #(.item_t(res_t), .DEPTH(RES_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr_item),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_item),
    .empty   (empty)
  );

  assign out_accepted       = res_rd_item.accepted;
  assign out_prefix_skipped = res_rd_item.prefix_skipped;
  assign out_host_len       = res_rd_item.host_len;
  assign out_port_number    = res_rd_item.port_number;

  // checks
  `ASSERT_NEVER(a_res_no_overflow, clk, rst_n, res_push && res_full)
  `ASSERT_IMPLIES(a_reject_zero, clk, rst_n, !empty && !out_accepted, (out_port_number == 16'd0) && (out_host_len == 6'd0) && !out_prefix_skipped)
  `ASSERT_NEXT(a_byte_queued, clk, rst_n, cls_wr, !cls_empty)

endmodule
